[rtl/core/tnpl_pkg.sv]
// Shared types and constants for the top-N peak list block.
package tnpl_pkg;

    // Configuration register indexes and widths
    localparam int CFG_INDEX_W      = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SEP_SQ   = 1'b1;
    localparam int ACTIVE_COUNT_W   = 5;
    localparam int MIN_SEP_W        = 22;
    localparam int CFG_DATA_W       = 22;
    localparam logic [ACTIVE_COUNT_W-1:0] ACTIVE_COUNT_RST = 5'd16;

    // Request kinds carried in tuser bit 0
    localparam logic REQ_OFFER   = 1'b0;
    localparam logic REQ_READOUT = 1'b1;

    // Distance sequence: three operand loads, then the sum settles
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_ROW  = 3'd0;
    localparam logic [PH_W-1:0] PH_COL  = 3'd1;
    localparam logic [PH_W-1:0] PH_RAD  = 3'd2;
    localparam logic [PH_W-1:0] PH_DONE = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAIL_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_DIST,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_OUT_RD,
        ST_OUT_LD
    } tnpl_state_t;

    // Control of the shared squared-difference accumulator
    typedef struct packed {
        logic load;   // square the operands this cycle
        logic first;  // this square restarts the sum
    } dist_ctrl_t;

endpackage

[rtl/core/tnpl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tnpl_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/tnpl_dist_unit.sv]
// Shared squared-difference unit with accumulator for peak distances.
module tnpl_dist_unit
    import tnpl_pkg::*;
#(
    parameter int DW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dist_ctrl_t      ctrl,
    input  logic [DW-1:0]   op_a,
    input  logic [DW-1:0]   op_b,
    output logic [2*DW+1:0] sum
);

    logic [DW-1:0]   diff;
    logic [2*DW-1:0] sq_next;
    logic [2*DW-1:0] sq_reg;
    logic [2*DW+1:0] acc_reg;
    logic            load_d_reg;
    logic            first_d_reg;

    assign diff    = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
    assign sq_next = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_d_reg  <= 1'b0;
            first_d_reg <= 1'b0;
        end
        else
        begin
            load_d_reg  <= ctrl.load;
            first_d_reg <= ctrl.first;
        end
    end

    // product registered, then accumulated in the cycle after
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sq_reg <= sq_next;
        end
        if (load_d_reg)
        begin
            acc_reg <= first_d_reg ? (2*DW+2)'(sq_reg)
                                   : acc_reg + (2*DW+2)'(sq_reg);
        end
    end

    assign sum = acc_reg;

endmodule

[rtl/core/top_n_peak_list_with_separation.sv]
// Top level of the top-N peak list with minimum separation between kept peaks.
//
// Usage: items arrive on the s_ stream. tuser bit 0 selects the request:
// an offer of a candidate peak, or a readout of the list. An offered
// candidate is kept if it is non-zero, flagged as a peak, beats the weakest
// active slot and lies at least the configured distance from every stronger
// entry; lower entries then move down one slot. A readout emits one item per
// active slot on the m_ stream, strongest first, tlast on the final slot,
// and then empties the list.
// Flow: s_tready is high only while the sequencer is idle. An offer that
// reaches the list is accepted, passes a tail check when the weakest slot
// is full, walks the stronger entries (read, compare and a five-step pass
// through the one shared squared-difference unit each), checks the slot
// that ends the walk and compares it if an entry is stored there, moves
// each slot below the insertion point with a read and a write, makes the
// last shift test and inserts. A readout reads each slot through the single
// RAM read port. Results sit in an output register, so a new item is taken
// while the last result still waits.
// Reset empties the list and loads the register defaults; the RAM needs no
// clearing. A stalled receiver holds the readout at its current slot.
module top_n_peak_list_with_separation
    import tnpl_pkg::*;
#(
    parameter int MAX_PEAKS      = 16,
    parameter int COORD_WIDTH    = 10,
    parameter int RADIUS_WIDTH   = 8,
    parameter int STRENGTH_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata from bit 0: row_pos, col_pos, radius_pos, vote_strength, zero fill
    input  logic [((2*COORD_WIDTH+RADIUS_WIDTH+STRENGTH_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser from bit 0: req_type, is_peak
    input  logic [1:0]             s_tuser,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata from bit 0: peak_row, peak_col, peak_radius, peak_strength, zero fill
    output logic [((2*COORD_WIDTH+RADIUS_WIDTH+STRENGTH_WIDTH+7)/8)*8-1:0] m_tdata,
    // m_tuser from bit 0: slot_used
    output logic [0:0]             m_tuser,
    output logic                   m_tlast
);

    localparam int ENTRY_W = 2*COORD_WIDTH + RADIUS_WIDTH + STRENGTH_WIDTH;
    localparam int TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int COL_LO  = COORD_WIDTH;
    localparam int RAD_LO  = 2*COORD_WIDTH;
    localparam int STR_LO  = 2*COORD_WIDTH + RADIUS_WIDTH;
    localparam int IDX_W   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W   = $clog2(MAX_PEAKS + 1);
    localparam int AW      = (CNT_W > ACTIVE_COUNT_W) ? CNT_W : ACTIVE_COUNT_W;
    localparam int DW      = (COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH;
    localparam int SUM_W   = 2*DW + 2;
    localparam int CMP_W   = (SUM_W > MIN_SEP_W) ? SUM_W : MIN_SEP_W;

    // configuration
    logic [ACTIVE_COUNT_W-1:0] active_count_reg;
    logic [MIN_SEP_W-1:0]      min_sep_reg;

    // sequencer
    tnpl_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [PH_W-1:0]       ph_reg, ph_next;
    logic [MAX_PEAKS-1:0]  valid_reg, valid_next;
    logic [ENTRY_W-1:0]    cand_reg;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [ENTRY_W-1:0]    m_data_reg, m_data_next;
    logic                  m_used_reg, m_used_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_load;

    // RAM and distance unit hookup
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    dist_ctrl_t            dist_ctrl;
    logic [DW-1:0]         dist_a, dist_b;
    logic [SUM_W-1:0]      dist_sum;

    logic                  s_accept;
    logic                  m_free;
    logic [AW-1:0]         ac_ext;
    logic [CNT_W-1:0]      n_eff;
    logic [IDX_W-1:0]      tail_idx;
    logic [IDX_W-1:0]      cur_idx;
    logic [STRENGTH_WIDTH-1:0] in_str, cand_str, ent_str;

    // slots in use, clamped to 1..MAX_PEAKS
    assign ac_ext   = AW'(active_count_reg);
    assign n_eff    = (ac_ext == '0) ? CNT_W'(1) :
                      (ac_ext > AW'(MAX_PEAKS)) ? CNT_W'(MAX_PEAKS) : CNT_W'(ac_ext);
    assign tail_idx = IDX_W'(n_eff - CNT_W'(1));
    assign cur_idx  = idx_reg[IDX_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_free   = !m_valid_reg || m_tready;

    assign in_str   = s_tdata[STR_LO +: STRENGTH_WIDTH];
    assign cand_str = cand_reg[STR_LO +: STRENGTH_WIDTH];
    assign ent_str  = ram_rdata[STR_LO +: STRENGTH_WIDTH];

    tnpl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PEAKS)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    tnpl_dist_unit #(
        .DW (DW)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dist_ctrl),
        .op_a  (dist_a),
        .op_b  (dist_b),
        .sum   (dist_sum)
    );

    // operand feed: one coordinate per phase, stored entry against candidate
    always_comb
    begin
        dist_ctrl.load  = (state_reg == ST_DIST) && (ph_reg <= PH_RAD);
        dist_ctrl.first = (ph_reg == PH_ROW);
        case (ph_reg)
            PH_ROW:
            begin
                dist_a = DW'(ram_rdata[0 +: COORD_WIDTH]);
                dist_b = DW'(cand_reg[0 +: COORD_WIDTH]);
            end
            PH_COL:
            begin
                dist_a = DW'(ram_rdata[COL_LO +: COORD_WIDTH]);
                dist_b = DW'(cand_reg[COL_LO +: COORD_WIDTH]);
            end
            PH_RAD:
            begin
                dist_a = DW'(ram_rdata[RAD_LO +: RADIUS_WIDTH]);
                dist_b = DW'(cand_reg[RAD_LO +: RADIUS_WIDTH]);
            end
            default:
            begin
                dist_a = '0;
                dist_b = '0;
            end
        endcase
    end

    // sequencer: next state, RAM port control and output register load
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        ph_next      = ph_reg;
        valid_next   = valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = k_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = cur_idx;
        m_load       = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_used_next  = m_used_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (s_accept)
                begin
                    if (s_tuser[0] == REQ_READOUT)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else if (in_str != '0 && s_tuser[1])
                    begin
                        if (valid_reg[tail_idx])
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = tail_idx;
                            state_next = ST_TAIL_CHK;
                        end
                        else
                        begin
                            state_next = ST_WALK_RD;
                        end
                    end
                end
            end

            // weakest active slot must be beaten
            ST_TAIL_CHK:
            begin
                state_next = (cand_str > ent_str) ? ST_WALK_RD : ST_IDLE;
            end

            ST_WALK_RD:
            begin
                if (idx_reg >= n_eff)
                begin
                    state_next = ST_IDLE;
                end
                else if (!valid_reg[cur_idx])
                begin
                    k_next     = tail_idx;
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_WALK_CHK;
                end
            end

            // walk stops at the first entry that is not stronger
            ST_WALK_CHK:
            begin
                if (cand_str < ent_str)
                begin
                    ph_next    = PH_ROW;
                    state_next = ST_DIST;
                end
                else
                begin
                    k_next     = tail_idx;
                    state_next = ST_SHIFT_RD;
                end
            end

            ST_DIST:
            begin
                if (ph_reg == PH_DONE)
                begin
                    if (CMP_W'(dist_sum) < CMP_W'(min_sep_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_WALK_RD;
                    end
                end
                else
                begin
                    ph_next = ph_reg + PH_W'(1);
                end
            end

            // move slots idx..n-2 down by one, from the bottom up
            ST_SHIFT_RD:
            begin
                if (k_reg > cur_idx)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = k_reg - IDX_W'(1);
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    state_next = ST_INSERT;
                end
            end

            ST_SHIFT_WR:
            begin
                ram_we            = 1'b1;
                ram_waddr         = k_reg;
                ram_wdata         = ram_rdata;
                valid_next[k_reg] = valid_reg[k_reg - IDX_W'(1)];
                k_next            = k_reg - IDX_W'(1);
                state_next        = ST_SHIFT_RD;
            end

            ST_INSERT:
            begin
                ram_we              = 1'b1;
                ram_waddr           = cur_idx;
                ram_wdata           = cand_reg;
                valid_next[cur_idx] = 1'b1;
                state_next          = ST_IDLE;
            end

            ST_OUT_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_OUT_LD;
            end

            // empty slots read out as zero
            ST_OUT_LD:
            begin
                if (m_free)
                begin
                    m_load       = 1'b1;
                    m_valid_next = 1'b1;
                    m_used_next  = valid_reg[cur_idx];
                    m_data_next  = valid_reg[cur_idx] ? ram_rdata : '0;
                    m_last_next  = (idx_reg == n_eff - CNT_W'(1));
                    if (idx_reg == n_eff - CNT_W'(1))
                    begin
                        valid_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            k_reg            <= '0;
            ph_reg           <= PH_ROW;
            valid_reg        <= '0;
            m_valid_reg      <= 1'b0;
            active_count_reg <= ACTIVE_COUNT_RST;
            min_sep_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            ph_reg      <= ph_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_index == CFG_ACTIVE_COUNT)
            begin
                active_count_reg <= cfg_data[ACTIVE_COUNT_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_MIN_SEP_SQ)
            begin
                min_sep_reg <= cfg_data[MIN_SEP_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cand_reg <= s_tdata[ENTRY_W-1:0];
        end
        if (m_load)
        begin
            m_data_reg <= m_data_next;
            m_used_reg <= m_used_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = TDATA_W'(m_data_reg);
    assign m_tuser[0] = m_used_reg;
    assign m_tlast    = m_last_reg;

endmodule
